/* hdl/cbs_pkg.sv */
// ----------------------------------------------------------------------------
// cbs_pkg
// Types and constants shared by the credit-based shaper register calculator.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_SPEED     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERF     = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Link speed codes; anything above SPEED_1G is an error
  localparam logic [1:0] SPEED_100M = 2'd0;
  localparam logic [1:0] SPEED_1G   = 2'd1;

  localparam logic [15:0] MAX_INTERF_RESET = 16'd1522;

  localparam logic [15:0] LINK_RATE        = 16'h7735;
  localparam logic [31:0] QUEUE_MODE_BIT   = 32'h8000_0000;
  localparam logic [31:0] ZERO_CREDIT_BASE = 32'h8000_0000;
  localparam logic [7:0]  FRAME_OVERHEAD   = 8'd43;

  // slope = (bw * 2 * LINK_RATE + 500000) / 1000000
  // 1000000 = 64 * 15625; the /15625 uses a reciprocal plus one correction
  localparam logic [15:0] SLOPE_MUL  = 16'd61034;
  localparam logic [18:0] ROUND_HALF = 19'd500000;
  localparam logic [13:0] DIV_LO     = 14'd15625;
  localparam logic [18:0] RECIP_LO   = 19'd274877;  // floor(2^32 / 15625)

  localparam int unsigned DVD_W     = 34;  // slope (16) * interference (18)
  localparam int unsigned DIV_STEPS = DVD_W;

  typedef struct packed {
    logic        err;
    logic        bad;       // class B with a class A slope that leaves no rate
    logic [30:0] divisor;
    logic [17:0] interf;
  } side_t;

  typedef struct packed {
    logic [30:0]      rem;
    logic [DVD_W-1:0] acc;   // dividend bits shift out, quotient bits shift in
    logic [30:0]      divisor;
    logic [15:0]      slope;
    logic             err;
    logic             big;
    logic             bad;
  } div_t;

endpackage

/* hdl/cbs_if.sv */
// ----------------------------------------------------------------------------
// cbs_if
// Valid/ready channels of the shaper calculator: request, result, config.
// ----------------------------------------------------------------------------
interface cbs_req_if;
  logic        valid;
  logic        ready;
  logic [19:0] bandwidth_kbps;
  logic        queue_select;
  logic [15:0] class_b_frame_bytes;
  logic [31:0] class_a_ctrl_word;

  modport source (output valid, bandwidth_kbps, queue_select, class_b_frame_bytes,
                  class_a_ctrl_word, input ready);
  modport sink   (input valid, bandwidth_kbps, queue_select, class_b_frame_bytes,
                  class_a_ctrl_word, output ready);
endinterface

interface cbs_rsp_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [31:0] hi_credit_word;
  logic [31:0] credit_ctrl_word;
  logic [15:0] idle_slope_value;
  logic        speed_error;

  modport source (output valid, write_valid, hi_credit_word, credit_ctrl_word,
                  idle_slope_value, speed_error, input ready);
  modport sink   (input valid, write_valid, hi_credit_word, credit_ctrl_word,
                  idle_slope_value, speed_error, output ready);
endinterface

interface cbs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cbs_pkg::CFG_IDX_W-1:0]    index;
  logic [cbs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/cbs_shaper_register_calc.sv */
// ----------------------------------------------------------------------------
// cbs_shaper_register_calc
// Credit-based shaper idle slope, hi-credit and credit-control word calculator.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per cycle in, one result per cycle out while
// rsp.ready takes results. Five stages form the rounded idle slope (multiply,
// round, reciprocal multiply, back-multiply, correction), one stage forms the
// hi-credit dividend, and a 34-stage restoring divider (one quotient bit per
// stage) divides it by the link rate or the reduced class B rate; the last
// register holds the result. Backpressure only stalls stages that hold data,
// so empty stages keep filling while a result waits. Config writes are
// always taken and must only happen while the pipeline is empty.
module cbs_shaper_register_calc (
  input  logic            clk,
  input  logic            rst,
  cbs_req_if.sink         req,
  cbs_rsp_if.source       rsp,
  cbs_cfg_if.sink         cfg
);

  localparam int unsigned DIV_BASE = 5;
  localparam int unsigned NS       = DIV_BASE + cbs_pkg::DIV_STEPS + 2;

  // Configuration
  logic [1:0]  link_speed_code;
  logic [15:0] max_interference_bytes;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_speed_code        <= cbs_pkg::SPEED_1G;
      max_interference_bytes <= cbs_pkg::MAX_INTERF_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        cbs_pkg::CFG_LINK_SPEED: link_speed_code        <= cfg.data[1:0];
        cbs_pkg::CFG_MAX_INTERF: max_interference_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // Valid bits and per-stage advance
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  assign adv[NS-1] = !vld[NS-1] || rsp.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_adv
    assign adv[i] = !vld[i] || adv[i+1];
  end

  assign req.ready = adv[0];
  assign rsp.valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= req.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: bandwidth product, class B rate and interference
  logic [31:0]   slope_a;
  logic [31:0]   diff;
  logic          a_unused;
  logic          use_b;
  logic          diff_ok;
  logic [17:0]   wide_interf;
  cbs_pkg::side_t side_in;

  always_comb begin
    slope_a     = req.class_a_ctrl_word ^ cbs_pkg::QUEUE_MODE_BIT;
    diff        = 32'(cbs_pkg::LINK_RATE) - slope_a;
    a_unused    = (slope_a == 32'd0) || (slope_a[15:0] == 16'hFFFF);
    use_b       = req.queue_select && !a_unused;
    diff_ok     = (diff != 32'd0) && !diff[31];
    wide_interf = 18'(max_interference_bytes) + 18'(req.class_b_frame_bytes)
                + 18'(cbs_pkg::FRAME_OVERHEAD);
    side_in.err     = (link_speed_code > cbs_pkg::SPEED_1G);
    side_in.bad     = use_b && !diff_ok;
    side_in.divisor = (use_b && diff_ok) ? diff[30:0] : 31'(cbs_pkg::LINK_RATE);
    side_in.interf  = use_b ? wide_interf : 18'(max_interference_bytes);
  end

  logic [35:0]    p1;
  cbs_pkg::side_t sd1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p1  <= 36'(req.bandwidth_kbps) * 36'(cbs_pkg::SLOPE_MUL);
      sd1 <= side_in;
    end
  end

  // Stage 2: round and drop the factor of 64
  logic [35:0]    p1_rnd;
  logic [29:0]    x2;
  cbs_pkg::side_t sd2;

  assign p1_rnd = p1 + 36'(cbs_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x2  <= p1_rnd[35:6];
      sd2 <= sd1;
    end
  end

  // Stage 3: reciprocal estimate of x / 15625, low by at most one
  logic [48:0]    p3;
  logic [29:0]    x3;
  logic [15:0]    q3;
  cbs_pkg::side_t sd3;

  assign p3 = 49'(x2) * 49'(cbs_pkg::RECIP_LO);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      x3  <= x2;
      q3  <= p3[47:32];
      sd3 <= sd2;
    end
  end

  // Stage 4: back-multiply
  logic [29:0]    x4;
  logic [15:0]    q4;
  logic [29:0]    m4;
  cbs_pkg::side_t sd4;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      x4  <= x3;
      q4  <= q3;
      m4  <= 30'(q3) * 30'(cbs_pkg::DIV_LO);
      sd4 <= sd3;
    end
  end

  // Stage 5: correction step gives the idle slope
  logic [29:0]    r5;
  logic [15:0]    slope5;
  cbs_pkg::side_t sd5;

  assign r5 = x4 - m4;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      slope5 <= q4 + 16'(r5 >= 30'(cbs_pkg::DIV_LO));
      sd5    <= sd4;
    end
  end

  // Stage 6 and divider: hi-credit quotient, one bit per stage
  cbs_pkg::div_t dv [0:cbs_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv[DIV_BASE]) begin
      dv[0].rem     <= '0;
      dv[0].acc     <= cbs_pkg::DVD_W'(slope5) * cbs_pkg::DVD_W'(sd5.interf);
      dv[0].divisor <= sd5.divisor;
      dv[0].slope   <= slope5;
      dv[0].err     <= sd5.err;
      dv[0].big     <= (slope5 >= cbs_pkg::LINK_RATE);
      dv[0].bad     <= sd5.bad;
    end
  end

  for (genvar k = 0; k < cbs_pkg::DIV_STEPS; k++) begin : g_div
    logic [31:0]   trial;
    logic          ge;
    cbs_pkg::div_t nxt;

    always_comb begin
      trial = {dv[k].rem, dv[k].acc[cbs_pkg::DVD_W-1]};
      ge    = (trial >= {1'b0, dv[k].divisor});
      nxt   = dv[k];
      nxt.rem = ge ? 31'(trial - {1'b0, dv[k].divisor}) : trial[30:0];
      nxt.acc = {dv[k].acc[cbs_pkg::DVD_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (adv[DIV_BASE+1+k]) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // Output register
  cbs_pkg::div_t dl;
  logic [31:0]   hc_next;
  logic [31:0]   cc_next;
  logic [15:0]   slope_next;

  always_comb begin
    dl         = dv[cbs_pkg::DIV_STEPS];
    hc_next    = '0;
    cc_next    = '0;
    slope_next = dl.slope;
    if (dl.err) begin
      slope_next = '0;
    end else if (dl.slope == 16'd0) begin
      hc_next = cbs_pkg::ZERO_CREDIT_BASE;
      cc_next = cbs_pkg::QUEUE_MODE_BIT;
    end else if (!dl.big) begin
      cc_next = cbs_pkg::QUEUE_MODE_BIT | 32'(dl.slope);
      hc_next = dl.bad ? 32'd0 : cbs_pkg::ZERO_CREDIT_BASE + dl.acc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      rsp.write_valid      <= (hc_next != 32'd0) && (cc_next != 32'd0);
      rsp.hi_credit_word   <= hc_next;
      rsp.credit_ctrl_word <= cc_next;
      rsp.idle_slope_value <= slope_next;
      rsp.speed_error      <= dl.err;
    end
  end

`ifndef SYNTHESIS
  // Write flag agrees with both words
  a_write_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.write_valid ==
      ((rsp.hi_credit_word != 32'd0) && (rsp.credit_ctrl_word != 32'd0)))
    else $error("write_valid does not match the credit words");

  a_speed_err: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.speed_error |->
      rsp.hi_credit_word == 32'd0 && rsp.credit_ctrl_word == 32'd0 &&
      rsp.idle_slope_value == 16'd0 && !rsp.write_valid)
    else $error("speed error with nonzero result");

  // Backpressure can only come from a held result
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("input stalled without a held result");

  a_ctrl_word: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.credit_ctrl_word != 32'd0 |->
      rsp.credit_ctrl_word[31] && rsp.credit_ctrl_word[30:16] == 15'd0 &&
      rsp.credit_ctrl_word[15:0] == rsp.idle_slope_value)
    else $error("credit control word inconsistent with idle slope");

  a_big_slope: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.speed_error && rsp.idle_slope_value >= cbs_pkg::LINK_RATE |->
      rsp.credit_ctrl_word == 32'd0 && rsp.hi_credit_word == 32'd0)
    else $error("oversized slope produced register words");
`endif

endmodule
